@@ src/rvl_pkg.sv @@
//------------------------------------------------------------------------------
// rvl_pkg
// Shared types and constants of the RVL depth frame decoder.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rvl_pkg;

	localparam int WORD_W     = 32;            // stream word
	localparam int NIB_W      = 4;             // one code nibble
	localparam int NIB_DATA_W = 3;             // data bits of a nibble
	localparam int NIBBLES    = WORD_W / NIB_W;
	localparam int NIB_CNT_W  = $clog2(NIBBLES);
	localparam int IDX_W      = 4;             // nibble index within a code
	localparam int SH_W       = 6;             // holds 3 * 15
	localparam int PIX_W      = 16;
	localparam int RUN_W      = 24;
	localparam int CFG_W      = 24;
	localparam logic [CFG_W-1:0] FRAME_PIXELS_RST = 24'd307200;
	localparam logic [IDX_W-1:0] IDX_MAX = 4'd15;

	typedef enum logic [1:0] {
		PH_ZEROS,
		PH_COUNT,
		PH_DELTA
	} phase_t;

	typedef enum logic {
		WK_DATA,
		WK_HEADER
	} word_kind_t;

	typedef struct packed {
		word_kind_t        kind;
		logic [WORD_W-1:0] word;
	} word_item_t;

	typedef struct packed {
		logic signed [PIX_W-1:0] pixel_value;
		logic [RUN_W-1:0]        run_length;
		logic                    frame_done;
		logic                    overrun_error;
	} result_t;

endpackage

`default_nettype wire

@@ src/rvl_stream_if.sv @@
//------------------------------------------------------------------------------
// rvl_stream_if
// Valid/ready channels for stream words in and decoded runs out.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rvl_word_if;
	logic        valid;
	logic        ready;
	logic [31:0] data_word;
	logic        frame_start;

	modport source (output valid, output data_word, output frame_start, input ready);
	modport sink   (input valid, input data_word, input frame_start, output ready);
endinterface

interface rvl_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] pixel_value;
	logic [23:0]        run_length;
	logic               frame_done;
	logic               overrun_error;
	logic               last_of_word;

	modport source (
		output valid, output pixel_value, output run_length, output frame_done,
		output overrun_error, output last_of_word, input ready
	);
	modport sink (
		input valid, input pixel_value, input run_length, input frame_done,
		input overrun_error, input last_of_word, output ready
	);
endinterface

`default_nettype wire

@@ src/rvl_depth_decoder.sv @@
//------------------------------------------------------------------------------
// rvl_depth_decoder
// Run-length / variable-length depth frame decompressor, top level.
//------------------------------------------------------------------------------
// words:   compressed stream, one 32-bit item a handshake; frame_start marks
//          the size header, which restarts decoding and gives no result
// results: decoded runs; a zero run is one item with pixel_value 0, every
//          nonzero pixel is an item with run_length 1; run_length 0 marks a
//          frame end (or an overrun, with overrun_error set)
// cfg:     cfg_wr_en / cfg_wr_data write frame_pixels, used at the next header
// a word's eight nibbles are decoded one per cycle unless results stalls;
// a header or a word after the frame end takes no nibble steps
// a word passes the front register and the queue into the nibble decoder;
// each run is then held in the pending slot until the next run or the end
// of its word fixes last_of_word, and is then offered from the output register
// the queue lets the front keep taking words while the decoder is busy
// after reset the block waits for a header; data words before it are dropped
// when results stalls the decoder holds at its current nibble and the queue
// fills; words then stalls; nothing is lost
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rvl_depth_decoder #(
	parameter int COUNT_WIDTH = 24,
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [23:0] cfg_wr_data,
	rvl_word_if.sink         words,
	rvl_result_if.source     results
);

	// frame size register
	logic [rvl_pkg::CFG_W-1:0] frame_pixels_q;

	// front to queue
	logic                      push_valid;
	logic                      push_ready;
	rvl_pkg::word_item_t       push_item;

	// queue to decoder
	logic                      pop_valid;
	logic                      pop_ready;
	rvl_pkg::word_item_t       pop_item;

	// decoder output slot
	rvl_pkg::result_t          out_result;
	logic                      out_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_pixels_q <= rvl_pkg::FRAME_PIXELS_RST;
		end else if (cfg_wr_en) begin
			frame_pixels_q <= cfg_wr_data;
		end
	end

	// takes words and tags headers
	rvl_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (words.valid),
		.in_data_word   (words.data_word),
		.in_frame_start (words.frame_start),
		.in_ready       (words.ready),
		.push_valid     (push_valid),
		.push_item      (push_item),
		.push_ready     (push_ready)
	);

	// decouples the front from the nibble decoder
	rvl_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item),
		.pop_ready  (pop_ready)
	);

	// one nibble a cycle unless results stalls, runs into the output register
	rvl_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_pixels (frame_pixels_q),
		.pop_valid    (pop_valid),
		.pop_item     (pop_item),
		.pop_ready    (pop_ready),
		.out_valid    (results.valid),
		.out_result   (out_result),
		.out_last     (out_last),
		.out_ready    (results.ready)
	);

	assign results.pixel_value   = out_result.pixel_value;
	assign results.run_length    = out_result.run_length;
	assign results.frame_done    = out_result.frame_done;
	assign results.overrun_error = out_result.overrun_error;
	assign results.last_of_word  = out_last;

endmodule

`default_nettype wire

@@ src/rvl_front.sv @@
//------------------------------------------------------------------------------
// rvl_front
// Input stage: takes stream words, tags headers, hands them to the queue.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rvl_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic [31:0]         in_data_word,
	input  wire logic                in_frame_start,
	output logic                     in_ready,
	output logic                     push_valid,
	output rvl_pkg::word_item_t      push_item,
	input  wire logic                push_ready
);

	logic                full_q;
	rvl_pkg::word_item_t item_s1;

	assign in_ready   = !full_q || push_ready;
	assign push_valid = full_q;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (in_ready) begin
			full_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.kind <= in_frame_start ? rvl_pkg::WK_HEADER : rvl_pkg::WK_DATA;
			item_s1.word <= in_data_word;
		end
	end

endmodule

`default_nettype wire

@@ src/rvl_queue.sv @@
//------------------------------------------------------------------------------
// rvl_queue
// Short FIFO of classified words between front and back.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rvl_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push_valid,
	input  wire rvl_pkg::word_item_t push_item,
	output logic                     push_ready,
	output logic                     pop_valid,
	output rvl_pkg::word_item_t      pop_item,
	input  wire logic                pop_ready
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	rvl_pkg::word_item_t entry_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    count_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

@@ src/rvl_back.sv @@
//------------------------------------------------------------------------------
// rvl_back
// Nibble decoder: one code nibble per cycle unless the output stalls, runs out through a held slot.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rvl_back #(
	parameter int COUNT_WIDTH = 24
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [23:0]         frame_pixels,
	input  wire logic                pop_valid,
	input  wire rvl_pkg::word_item_t pop_item,
	output logic                     pop_ready,
	output logic                     out_valid,
	output rvl_pkg::result_t         out_result,
	output logic                     out_last,
	input  wire logic                out_ready
);

	localparam int AW = rvl_pkg::WORD_W;

	// decoder state
	logic                             busy_q;
	logic [AW-1:0]                    word_q;
	logic [rvl_pkg::NIB_CNT_W-1:0]    cnt_q;
	rvl_pkg::phase_t                  phase_q;
	logic [AW-1:0]                    acc_q;
	logic [rvl_pkg::IDX_W-1:0]        idx_q;
	logic [COUNT_WIDTH-1:0]           pix_rem_q;
	logic [COUNT_WIDTH-1:0]           drem_q;
	logic [rvl_pkg::PIX_W-1:0]        prev_q;
	logic                             fin_q;

	// pending result, waits until the word shows whether it is the last
	logic                             pend_valid_q;
	logic                             pend_last_q;
	rvl_pkg::result_t                 pend_q;
	logic                             out_valid_q;
	logic                             out_last_q;
	rvl_pkg::result_t                 out_q;

	logic [rvl_pkg::NIB_W-1:0]        nib;
	logic [rvl_pkg::SH_W-1:0]         sh;
	logic [AW-1:0]                    acc_new;
	logic [rvl_pkg::IDX_W-1:0]        idx_new;
	logic [AW-1:0]                    v;
	logic [rvl_pkg::PIX_W-1:0]        d16;
	logic [COUNT_WIDTH-1:0]           drem_dec;
	logic [COUNT_WIDTH-1:0]           pix_sub;

	rvl_pkg::phase_t                  n_phase;
	logic [AW-1:0]                    n_acc;
	logic [rvl_pkg::IDX_W-1:0]        n_idx;
	logic [COUNT_WIDTH-1:0]           n_pix_rem;
	logic [COUNT_WIDTH-1:0]           n_drem;
	logic [rvl_pkg::PIX_W-1:0]        n_prev;
	logic                             n_fin;
	logic                             r_valid;
	rvl_pkg::result_t                 r;

	logic                             out_free;
	logic                             step;
	logic                             final_step;
	logic                             do_pop;
	logic                             fin_after;
	logic                             load_out;
	rvl_pkg::result_t                 out_d;
	logic                             out_last_d;
	logic                             n_pend_valid;
	logic                             n_pend_last;
	rvl_pkg::result_t                 n_pend;

	assign out_valid  = out_valid_q;
	assign out_result = out_q;
	assign out_last   = out_last_q;

	// one nibble: accumulate, and on the closing nibble act on the code
	always_comb begin
		nib      = word_q[AW-1 -: rvl_pkg::NIB_W];
		sh       = ({2'b00, idx_q} << 1) + {2'b00, idx_q};
		acc_new  = acc_q;
		if (sh < rvl_pkg::SH_W'(AW)) begin
			acc_new = acc_q | (AW'(nib[rvl_pkg::NIB_DATA_W-1:0]) << sh[4:0]);
		end
		idx_new  = (idx_q == rvl_pkg::IDX_MAX) ? idx_q : idx_q + 1'b1;
		v        = acc_new;
		d16      = v[rvl_pkg::PIX_W:1] ^ {rvl_pkg::PIX_W{v[0]}};
		drem_dec = (drem_q != '0) ? drem_q - 1'b1 : drem_q;
		pix_sub  = pix_rem_q - v[COUNT_WIDTH-1:0];

		n_phase   = phase_q;
		n_acc     = acc_new;
		n_idx     = idx_new;
		n_pix_rem = pix_rem_q;
		n_drem    = drem_q;
		n_prev    = prev_q;
		n_fin     = fin_q;
		r_valid   = 1'b0;
		r         = '0;

		if (!nib[rvl_pkg::NIB_W-1]) begin
			n_acc = '0;
			n_idx = '0;
			if (phase_q == rvl_pkg::PH_DELTA) begin
				n_prev = prev_q + d16;
				n_drem = drem_dec;
				if (drem_dec == '0) begin
					n_phase = rvl_pkg::PH_ZEROS;
					if (pix_rem_q == '0) begin
						n_fin = 1'b1;
					end
				end
				r_valid            = 1'b1;
				r.pixel_value      = n_prev;
				r.run_length       = rvl_pkg::RUN_W'(1);
				r.frame_done       = n_fin;
			end else if (v > AW'(pix_rem_q)) begin
				// count overshoots the frame
				n_fin           = 1'b1;
				r_valid         = 1'b1;
				r.frame_done    = 1'b1;
				r.overrun_error = 1'b1;
			end else if (phase_q == rvl_pkg::PH_ZEROS) begin
				n_pix_rem    = pix_sub;
				n_phase      = rvl_pkg::PH_COUNT;
				r_valid      = (v != '0);
				r.run_length = v[rvl_pkg::RUN_W-1:0];
			end else begin
				n_pix_rem = pix_sub;
				n_drem    = v[COUNT_WIDTH-1:0];
				if (v != '0) begin
					n_phase = rvl_pkg::PH_DELTA;
				end else begin
					n_phase = rvl_pkg::PH_ZEROS;
					if (pix_sub == '0) begin
						// end marker
						n_fin        = 1'b1;
						r_valid      = 1'b1;
						r.frame_done = 1'b1;
					end
				end
			end
		end
	end

	// stepping, word hand-over and the pending / output slots
	always_comb begin
		out_free   = !out_valid_q || out_ready;
		step       = busy_q && (!pend_valid_q || out_free);
		final_step = (cnt_q == rvl_pkg::NIB_CNT_W'(rvl_pkg::NIBBLES - 1)) || n_fin;
		pop_ready  = !busy_q || (step && final_step);
		do_pop     = pop_valid && pop_ready;
		fin_after  = step ? n_fin : fin_q;

		load_out     = 1'b0;
		out_d        = pend_q;
		out_last_d   = pend_last_q;
		n_pend_valid = pend_valid_q;
		n_pend_last  = pend_last_q;
		n_pend       = pend_q;
		if (step && r_valid) begin
			load_out     = pend_valid_q;
			n_pend_valid = 1'b1;
			n_pend       = r;
			n_pend_last  = final_step;
		end else if (pend_valid_q && pend_last_q && out_free) begin
			load_out     = 1'b1;
			n_pend_valid = 1'b0;
		end else if (step && final_step && pend_valid_q) begin
			n_pend_last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			cnt_q        <= '0;
			phase_q      <= rvl_pkg::PH_ZEROS;
			acc_q        <= '0;
			idx_q        <= '0;
			pix_rem_q    <= COUNT_WIDTH'(rvl_pkg::FRAME_PIXELS_RST);
			drem_q       <= '0;
			prev_q       <= '0;
			fin_q        <= 1'b1;
			pend_valid_q <= 1'b0;
			pend_last_q  <= 1'b0;
			out_valid_q  <= 1'b0;
			out_last_q   <= 1'b0;
		end else begin
			if (step) begin
				phase_q   <= n_phase;
				acc_q     <= n_acc;
				idx_q     <= n_idx;
				pix_rem_q <= n_pix_rem;
				drem_q    <= n_drem;
				prev_q    <= n_prev;
				fin_q     <= n_fin;
				cnt_q     <= cnt_q + 1'b1;
				if (final_step) begin
					busy_q <= 1'b0;
				end
			end
			if (do_pop) begin
				cnt_q <= '0;
				if (pop_item.kind == rvl_pkg::WK_HEADER) begin
					busy_q    <= 1'b0;
					phase_q   <= rvl_pkg::PH_ZEROS;
					acc_q     <= '0;
					idx_q     <= '0;
					pix_rem_q <= COUNT_WIDTH'(frame_pixels);
					drem_q    <= '0;
					prev_q    <= '0;
					fin_q     <= 1'b0;
				end else begin
					busy_q <= !fin_after;
				end
			end
			pend_valid_q <= n_pend_valid;
			pend_last_q  <= n_pend_last;
			if (load_out) begin
				out_valid_q <= 1'b1;
				out_last_q  <= out_last_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			word_q <= word_q << rvl_pkg::NIB_W;
		end
		if (do_pop) begin
			word_q <= pop_item.word;
		end
		pend_q <= n_pend;
		if (load_out) begin
			out_q <= out_d;
		end
	end

endmodule

`default_nettype wire

@@ src/rvl_checker.sv @@
//------------------------------------------------------------------------------
// rvl_checker
// Port-level checks on the decoded run stream, bound to the top level.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rvl_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               valid,
	input  wire logic               ready,
	input  wire logic signed [15:0] pixel_value,
	input  wire logic [23:0]        run_length,
	input  wire logic               frame_done,
	input  wire logic               overrun_error,
	input  wire logic               last_of_word
);

	// a stalled item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(pixel_value) && $stable(run_length)
			&& $stable(frame_done) && $stable(overrun_error) && $stable(last_of_word))
		else $error("result changed while stalled");

	// an overrun ends the frame with an empty run
	a_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid && overrun_error |-> frame_done && run_length == '0 && pixel_value == '0)
		else $error("overrun item malformed");

	// empty runs only at the frame end
	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		valid && run_length == '0 |-> frame_done)
		else $error("empty run outside frame end");

	// nonzero pixels come one at a time
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		valid && pixel_value != '0 |-> run_length == 24'd1)
		else $error("nonzero pixel with run length other than one");

	// rest of the word is dropped after the frame end
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && frame_done |-> last_of_word)
		else $error("frame end not last of its word");

endmodule

bind rvl_depth_decoder rvl_checker u_rvl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.valid         (results.valid),
	.ready         (results.ready),
	.pixel_value   (results.pixel_value),
	.run_length    (results.run_length),
	.frame_done    (results.frame_done),
	.overrun_error (results.overrun_error),
	.last_of_word  (results.last_of_word)
);

`default_nettype wire
